// ===== rtl/core/gtrc_pkg.sv =====
// Package for the gamepad to RC channel mapper.
// Holds word types, command and mode codes, constant dividers and clamps.
// No dependencies.
package gtrc_pkg;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         number;
      logic signed [15:0] value;
   } req_word_type;

   typedef struct packed {
      logic [11:0] throttle;
      logic [11:0] roll;
      logic [11:0] pitch;
      logic [11:0] yaw;
      logic [10:0] arm_channel;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         number;
      logic               pressed;
      logic               axis_ok;
      logic [1:0]         pair;
      logic signed [15:0] cur_x;
      logic signed [15:0] cur_y;
      logic signed [15:0] x1;
      logic signed [15:0] y2;
      logic signed [11:0] qx500;
      logic signed [11:0] qy500;
      logic signed [11:0] qy50;
      logic signed [11:0] qxd;
      logic signed [11:0] qyd;
   } task_word_type;

   typedef struct packed {
      logic [11:0]        thr;
      logic [11:0]        roll;
      logic [11:0]        pitch;
      logic [11:0]        yaw;
      logic [11:0]        target;
      logic [11:0]        mid;
      logic [10:0]        arm_lvl;
      logic               armed;
      logic               lth;
      logic               rth;
      logic signed [15:0] left_last;
      logic signed [15:0] right_last;
   } map_state_type;

   localparam logic [1:0] CMD_BUTTON = 2'd0;
   localparam logic [1:0] CMD_AXIS   = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   localparam logic [2:0] MODE_USUAL      = 3'd0;
   localparam logic [2:0] MODE_INERTIAL   = 3'd1;
   localparam logic [2:0] MODE_CASUAL     = 3'd2;
   localparam logic [2:0] MODE_TRIG_USUAL = 3'd3;
   localparam logic [2:0] MODE_TRIG_FULL  = 3'd4;
   localparam logic [2:0] MODE_TRIG_EXTR  = 3'd5;

   localparam logic CSR_MODE   = 1'b0;
   localparam logic CSR_LAYOUT = 1'b1;

   localparam int DIV_N = 17;
   localparam logic [4:0]  SHIFT_500 = 5'(DIV_N + $clog2(500));
   localparam logic [17:0] RECIP_500 = 18'(((2**(DIV_N + $clog2(500))) + 499) / 500);
   localparam logic [4:0]  SHIFT_50  = 5'(DIV_N + $clog2(50));
   localparam logic [17:0] RECIP_50  = 18'(((2**(DIV_N + $clog2(50))) + 49) / 50);
   localparam logic [4:0]  SHIFT_120 = 5'(DIV_N + $clog2(120));
   localparam logic [17:0] RECIP_120 = 18'(((2**(DIV_N + $clog2(120))) + 119) / 120);
   localparam logic [4:0]  SHIFT_60  = 5'(DIV_N + $clog2(60));
   localparam logic [17:0] RECIP_60  = 18'(((2**(DIV_N + $clog2(60))) + 59) / 60);
   localparam logic [4:0]  SHIFT_188 = 5'(DIV_N + $clog2(188));
   localparam logic [17:0] RECIP_188 = 18'(((2**(DIV_N + $clog2(188))) + 187) / 188);
   localparam logic [4:0]  SHIFT_85  = 5'(DIV_N + $clog2(85));
   localparam logic [17:0] RECIP_85  = 18'(((2**(DIV_N + $clog2(85))) + 84) / 85);

   // truncate toward zero: scale the magnitude by the reciprocal, restore sign
   function automatic logic signed [16:0] div_const(input logic signed [16:0] a,
                                                    input logic [17:0] recip,
                                                    input logic [4:0] shift);
      logic [16:0] mag;
      logic [35:0] prod;
      logic [16:0] q;
      mag  = a[16] ? 17'(-a) : 17'(a);
      prod = 36'(mag) * 36'(recip);
      q    = 17'(prod >> shift);
      return a[16] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [11:0] clip_stick(input logic signed [13:0] v);
      if (v > 14'sd2100) return 12'd2099;
      if (v < 14'sd900) return 12'd901;
      return v[11:0];
   endfunction

   function automatic logic [11:0] clip_thr(input logic signed [13:0] v);
      if (v > 14'sd1800) return 12'd1799;
      if (v < 14'sd900) return 12'd901;
      return v[11:0];
   endfunction

endpackage

// ===== rtl/core/gamepad_to_rc_channel_mapper.sv =====
// Top level of the gamepad to RC channel mapper: front end, queue, back end.
// Depends on gtrc_pkg, gtrc_front, gtrc_queue, gtrc_back.
//
//   port group   dir   handshake        word
//   req_         in    valid / stall    req_word_type
//   rsp_         out   valid / stall    rsp_word_type
//   csr_         in    valid / ready    index, data
//
// One word per cycle sustained while rsp_stall stays low; a request is registered on
// its way to a result (front end into the queue, back end into the output register).
// Synchronous active-high reset restores stick and channel state.
// A stalled result holds; the two-entry queue takes requests until it is full.
module gamepad_to_rc_channel_mapper import gtrc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [2:0]   csr_data
);

   logic [2:0]    mode_ff;
   logic          layout_ff;
   logic          push, pop, full, empty;
   task_word_type push_word, head_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_USUAL;
         layout_ff <= 1'b0;
      end else if (csr_valid) begin
         if (csr_index == CSR_MODE) mode_ff <= csr_data;
         if (csr_index == CSR_LAYOUT) layout_ff <= csr_data[0];
      end
   end

   gtrc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_mode   (mode_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_word  (push_word)
   );

   gtrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .full      (full),
      .empty     (empty)
   );

   gtrc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_mode   (mode_ff),
      .cfg_layout (layout_ff),
      .empty      (empty),
      .head_word  (head_word),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   a_arm_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.arm_channel == 11'd900 || rsp_data.arm_channel == 11'd1900))
      else $error("arm channel off its two levels");

   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.throttle >= 12'd900 && rsp_data.throttle <= 12'd2100))
      else $error("throttle out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity right after reset");

endmodule

// ===== rtl/core/gtrc_front.sv =====
// Front end: accepts request words, keeps stick positions, precomputes quotients.
// Depends on gtrc_pkg.
module gtrc_front import gtrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [2:0]    cfg_mode,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_word_type  req_data,
   input  logic          queue_full,
   output logic          push,
   output task_word_type push_word
);

   logic signed [15:0] stick_ff [6];
   logic signed [15:0] stick_new [6];
   logic               axis_ok;
   logic [1:0]         pair;
   logic signed [15:0] cur_x;
   logic signed [15:0] cur_y;
   logic [17:0]        recip_d;
   logic [4:0]         shift_d;
   logic signed [16:0] qx500, qy500, qy50, qxd, qyd;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign pair      = req_data.number[2:1];
   assign axis_ok   = (req_data.command == CMD_AXIS) && (req_data.number < 8'd6) &&
                      (cfg_mode <= MODE_TRIG_EXTR);

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         stick_new[i] = stick_ff[i];
      end
      if (axis_ok) begin
         stick_new[req_data.number[2:0]] = req_data.value;
      end
      cur_x = stick_new[{pair, 1'b0}];
      cur_y = stick_new[{pair, 1'b1}];
   end

   always_comb begin
      if (cfg_mode == MODE_TRIG_USUAL) begin
         recip_d = RECIP_500;
         shift_d = SHIFT_500;
      end else if (cfg_mode == MODE_TRIG_FULL) begin
         recip_d = RECIP_120;
         shift_d = SHIFT_120;
      end else begin
         recip_d = RECIP_60;
         shift_d = SHIFT_60;
      end
   end

   assign qx500 = div_const(17'(cur_x), RECIP_500, SHIFT_500);
   assign qy500 = div_const(17'(cur_y), RECIP_500, SHIFT_500);
   assign qy50  = div_const(17'(cur_y), RECIP_50, SHIFT_50);
   assign qxd   = div_const(17'(cur_x), recip_d, shift_d);
   assign qyd   = div_const(17'(cur_y), recip_d, shift_d);

   always_comb begin
      push_word.command = req_data.command;
      push_word.number  = req_data.number;
      push_word.pressed = (req_data.value != 16'sd0);
      push_word.axis_ok = axis_ok;
      push_word.pair    = pair;
      push_word.cur_x   = cur_x;
      push_word.cur_y   = cur_y;
      push_word.x1      = stick_new[3'd2];
      push_word.y2      = stick_new[3'd5];
      push_word.qx500   = qx500[11:0];
      push_word.qy500   = qy500[11:0];
      push_word.qy50    = qy50[11:0];
      push_word.qxd     = qxd[11:0];
      push_word.qyd     = qyd[11:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            stick_ff[i] <= 16'sd0;
         end
      end else if (push && axis_ok) begin
         stick_ff[req_data.number[2:0]] <= req_data.value;
      end
   end

endmodule

// ===== rtl/core/gtrc_queue.sv =====
// Two-entry queue between front end and back end.
// Depends on gtrc_pkg.
module gtrc_queue import gtrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  task_word_type push_word,
   input  logic          pop,
   output task_word_type head_word,
   output logic          full,
   output logic          empty
);

   task_word_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/core/gtrc_back.sv =====
// Back end: applies queued words to the channel state, holds the result word.
// Depends on gtrc_pkg.
module gtrc_back import gtrc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [2:0]    cfg_mode,
   input  logic          cfg_layout,
   input  logic          empty,
   input  task_word_type head_word,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_word_type  rsp_data
);

   map_state_type st_ff, st_in;
   rsp_word_type  out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   function automatic map_state_type arming(input map_state_type s, input logic on);
      map_state_type r;
      r = s;
      if (on) begin
         r.thr        = 12'd930;
         r.left_last  = 16'sd32767;
         r.right_last = -16'sd32767;
         r.target     = 12'd1500;
         r.arm_lvl    = 11'd1900;
         r.armed      = 1'b1;
      end else if (s.armed) begin
         r.thr        = 12'd1100;
         r.target     = 12'd1500;
         r.left_last  = -16'sd32767;
         r.right_last = -16'sd32767;
         r.armed      = 1'b0;
      end
      return r;
   endfunction

   function automatic map_state_type neutral(input map_state_type s);
      map_state_type r;
      r        = s;
      r.thr    = 12'd1100;
      r.roll   = 12'd1500;
      r.pitch  = 12'd1500;
      r.yaw    = 12'd1500;
      r.target = 12'd1500;
      return r;
   endfunction

   function automatic logic [11:0] trig_thr(input map_state_type s, input logic slow);
      logic signed [16:0] diff;
      logic signed [16:0] q;
      diff = 17'(s.right_last) - 17'(s.left_last);
      q    = slow ? div_const(diff, RECIP_188, SHIFT_188) : div_const(diff, RECIP_85, SHIFT_85);
      return clip_thr(14'sd1300 + 14'(q));
   endfunction

   function automatic logic [11:0] plus(input logic signed [11:0] q);
      return clip_stick(14'sd1500 + 14'(q));
   endfunction

   function automatic logic [11:0] minus(input logic signed [11:0] q);
      return clip_stick(14'sd1500 - 14'(q));
   endfunction

   logic               big;
   logic               on;
   logic [7:0]         n;
   logic [1:0]         p;
   logic signed [13:0] tdiff;
   task_word_type      t;

   assign big = cfg_layout;
   assign t   = head_word;
   assign on  = t.pressed;
   assign n   = t.number;
   assign p   = t.pair;
   assign pop = !empty && (!out_valid_ff || !rsp_stall);
   assign tdiff = 14'($signed({2'b00, st_ff.target})) - 14'sd1500;

   always_comb begin
      st_in = st_ff;
      case (t.command)
         CMD_BUTTON: begin
            case (cfg_mode)
               MODE_USUAL: begin
                  if (!big && n == 8'd7) st_in = arming(st_in, on);
                  if (n == 8'd5 && on) st_in.arm_lvl = 11'd900;
               end
               MODE_INERTIAL: begin
                  if (!big && n == 8'd7) st_in = arming(st_in, on);
                  if (n == 8'd5 && on) st_in.arm_lvl = 11'd900;
                  if (!big && n == 8'd6 && on) st_in = neutral(st_in);
                  if (n == 8'd4 && on) begin
                     st_in.thr    = st_in.mid;
                     st_in.target = 12'd1500;
                  end
                  if (n == 8'd3 && on) st_in.mid = st_in.thr;
               end
               MODE_CASUAL: begin
                  if (n == 8'd5) st_in = arming(st_in, on);
                  if (n == 8'd4 && on) st_in.arm_lvl = 11'd900;
                  if (!big) begin
                     if (n == 8'd7 && !st_in.lth) begin
                        st_in.rth = on;
                        st_in.thr = on ? 12'd1500 : st_in.mid;
                     end
                     if (n == 8'd6 && !st_in.rth) begin
                        st_in.lth = on;
                        st_in.thr = on ? 12'd1250 : st_in.mid;
                     end
                  end
               end
               MODE_TRIG_USUAL, MODE_TRIG_FULL, MODE_TRIG_EXTR: begin
                  if (!big) begin
                     if (n == 8'd7) st_in = arming(st_in, on);
                     if (n == 8'd5 && on) st_in.arm_lvl = 11'd900;
                  end else begin
                     if (n == 8'd5) st_in = arming(st_in, on);
                     if (n == 8'd4 && on) st_in.arm_lvl = 11'd900;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_AXIS: begin
            if (t.axis_ok) begin
               if (!big) begin
                  if (cfg_mode <= MODE_INERTIAL) begin
                     if (p == 2'd0) begin
                        st_in.yaw = plus(t.qx500);
                        if (cfg_mode == MODE_USUAL) begin
                           st_in.thr = minus(t.qy50);
                        end else begin
                           st_in.target = 12'(14'sd1500 - 14'(t.qy50));
                           st_in.thr    = clip_stick(14'($signed({2'b00, st_in.thr})));
                        end
                     end
                     if (p == 2'd1) begin
                        st_in.pitch = minus(t.qy500);
                        st_in.roll  = plus(t.qx500);
                     end
                  end else begin
                     if (p == 2'd0) begin
                        st_in.pitch = minus(t.qy500);
                        st_in.roll  = plus(t.qx500);
                     end
                     if (p == 2'd1) st_in.yaw = plus(t.qx500);
                  end
               end else begin
                  case (cfg_mode)
                     MODE_USUAL, MODE_INERTIAL: begin
                        if (p == 2'd0) begin
                           st_in.yaw = plus(t.qx500);
                           if (cfg_mode == MODE_USUAL) begin
                              st_in.thr = minus(t.qy50);
                           end else begin
                              st_in.target = 12'(14'sd1500 - 14'(t.qy50));
                              st_in.thr    = clip_stick(14'($signed({2'b00, st_in.thr})));
                           end
                        end
                        if (p == 2'd1) begin
                           st_in.roll = plus(t.qy500);
                           if (cfg_mode == MODE_INERTIAL && t.cur_x > -16'sd29000) begin
                              st_in = neutral(st_in);
                           end
                        end
                        if (p == 2'd2) begin
                           st_in.pitch = minus(t.qx500);
                           st_in = arming(st_in, t.cur_y > 16'sd10000);
                        end
                     end
                     MODE_CASUAL: begin
                        if (p == 2'd0) st_in.roll = plus(t.qx500);
                        if (p == 2'd1) begin
                           if (t.cur_x > 16'sd10000 && !st_in.rth) begin
                              st_in.lth = 1'b1;
                              st_in.thr = 12'd1250;
                           end
                           if (t.cur_x < 16'sd10000 && !st_in.rth) begin
                              st_in.lth = 1'b0;
                              st_in.thr = st_in.mid;
                           end
                           st_in.yaw = plus(t.qy500);
                        end
                        if (p == 2'd2) begin
                           st_in.pitch = minus(t.qx500);
                           if (t.cur_y > 16'sd10000 && !st_in.lth) begin
                              st_in.rth = 1'b1;
                              st_in.thr = 12'd1550;
                           end
                           if (t.cur_y < 16'sd10000 && !st_in.lth) begin
                              st_in.rth = 1'b0;
                              st_in.thr = st_in.mid;
                           end
                        end
                     end
                     default: begin
                        if (p == 2'd0) begin
                           st_in.roll  = plus(t.qxd);
                           st_in.pitch = minus(t.qyd);
                        end
                        if (p == 2'd1) st_in.yaw = plus(t.qyd);
                        if (cfg_mode == MODE_TRIG_EXTR) begin
                           if (p != 2'd0) begin
                              st_in.left_last  = t.x1;
                              st_in.right_last = t.y2;
                           end
                        end else begin
                           if (p == 2'd1) st_in.left_last = t.cur_x;
                           if (p == 2'd2) st_in.right_last = t.cur_y;
                        end
                        st_in.thr = trig_thr(st_in, cfg_mode == MODE_TRIG_USUAL);
                     end
                  endcase
               end
            end
         end
         CMD_TICK: begin
            if (cfg_mode == MODE_INERTIAL) begin
               if (tdiff > 14'sd100) st_in.thr = st_in.thr + 12'd1;
               if (tdiff < -14'sd100) st_in.thr = st_in.thr - 12'd1;
               st_in.thr = clip_thr(14'($signed({2'b00, st_in.thr})));
            end
            if (cfg_mode == MODE_TRIG_USUAL) st_in.thr = trig_thr(st_in, 1'b1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_in.throttle    = st_in.thr;
      out_in.roll        = st_in.roll;
      out_in.pitch       = st_in.pitch;
      out_in.yaw         = st_in.yaw;
      out_in.arm_channel = st_in.arm_lvl;
      out_valid_in       = pop || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.thr        <= 12'd1239;
         st_ff.roll       <= 12'd1500;
         st_ff.pitch      <= 12'd1500;
         st_ff.yaw        <= 12'd1500;
         st_ff.target     <= 12'd1500;
         st_ff.mid        <= 12'd1500;
         st_ff.arm_lvl    <= 11'd900;
         st_ff.armed      <= 1'b0;
         st_ff.lth        <= 1'b0;
         st_ff.rth        <= 1'b0;
         st_ff.left_last  <= -16'sd32767;
         st_ff.right_last <= -16'sd32767;
         out_valid_ff     <= 1'b0;
      end else begin
         if (pop) st_ff <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== tb/testbench.sv =====
// Testbench for the gamepad to RC channel mapper: queued driver, clocked monitor,
// in-bench channel predictor checked word by word. Depends on gtrc_pkg and the RTL.
`timescale 1ns / 100ps
module testbench;
   import gtrc_pkg::*;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 0;
   rsp_word_type rsp_data;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic         csr_index = 0;
   logic [2:0]   csr_data = 0;

   gamepad_to_rc_channel_mapper i_dut (.*);

   initial forever #6 clock = ~clock;

   // channel state mirror
   int cfg_mode, cfg_big;
   int sticks [6];
   int thr, rol, pit, yw, tgt, mid, arm_lvl, lt_last, rt_last;
   bit armed, lth, rth;

   req_word_type pending_words[$];
   rsp_word_type channel_queue[$];
   int mismatches = 0;
   int send_idle = 0, recv_idle = 0, holdoff = 0;

   function automatic int tdiv(int a, int d);
      int q;
      q = (a < 0 ? -a : a) / d;
      return a < 0 ? -q : q;
   endfunction
   function automatic int clip_s(int v);
      return v > 2100 ? 2099 : (v < 900 ? 901 : v);
   endfunction
   function automatic int clip_t(int v);
      return v > 1800 ? 1799 : (v < 900 ? 901 : v);
   endfunction

   task automatic arm_event(bit on);
      if (on) begin
         thr = 930; lt_last = 32767; rt_last = -32767; tgt = 1500;
         arm_lvl = 1900; armed = 1;
      end else if (armed) begin
         thr = 1100; tgt = 1500; lt_last = -32767; rt_last = -32767; armed = 0;
      end
   endtask

   task automatic go_neutral();
      thr = 1100; rol = 1500; pit = 1500; yw = 1500; tgt = 1500;
   endtask

   task automatic predict_channels(req_word_type w);
      int n, v, pair, d;
      bit on;
      rsp_word_type r;
      n = w.number; v = w.value; on = (v != 0); pair = n / 2;
      if (w.command == CMD_BUTTON) begin
         case (cfg_mode)
            MODE_USUAL: begin
               if (!cfg_big && n == 7) arm_event(on);
               if (n == 5 && on) arm_lvl = 900;
            end
            MODE_INERTIAL: begin
               if (!cfg_big && n == 7) arm_event(on);
               if (n == 5 && on) arm_lvl = 900;
               if (!cfg_big && n == 6 && on) go_neutral();
               if (n == 4 && on) begin thr = mid; tgt = 1500; end
               if (n == 3 && on) mid = thr;
            end
            MODE_CASUAL: begin
               if (n == 5) arm_event(on);
               if (n == 4 && on) arm_lvl = 900;
               if (!cfg_big) begin
                  if (n == 7 && on && !lth) begin rth = 1; thr = 1500; end
                  if (n == 7 && !on && !lth) begin rth = 0; thr = mid; end
                  if (n == 6 && on && !rth) begin lth = 1; thr = 1250; end
                  if (n == 6 && !on && !rth) begin lth = 0; thr = mid; end
               end
            end
            MODE_TRIG_USUAL, MODE_TRIG_FULL, MODE_TRIG_EXTR: begin
               if (!cfg_big) begin
                  if (n == 7) arm_event(on);
                  if (n == 5 && on) arm_lvl = 900;
               end else begin
                  if (n == 5) arm_event(on);
                  if (n == 4 && on) arm_lvl = 900;
               end
            end
            default: ;
         endcase
      end else if (w.command == CMD_AXIS && cfg_mode <= 5 && pair < 3) begin
         sticks[n] = v;
         if (!cfg_big) begin
            if (cfg_mode <= 1) begin
               if (pair == 0) begin
                  yw = clip_s(1500 + tdiv(sticks[0], 500));
                  if (cfg_mode == 0) thr = clip_s(1500 - tdiv(sticks[1], 50));
                  else begin tgt = 1500 - tdiv(sticks[1], 50); thr = clip_s(thr); end
               end
               if (pair == 1) begin
                  pit = clip_s(1500 - tdiv(sticks[3], 500));
                  rol = clip_s(1500 + tdiv(sticks[2], 500));
               end
            end else begin
               if (pair == 0) begin
                  pit = clip_s(1500 - tdiv(sticks[1], 500));
                  rol = clip_s(1500 + tdiv(sticks[0], 500));
               end
               if (pair == 1) yw = clip_s(1500 + tdiv(sticks[2], 500));
            end
         end else if (cfg_mode <= 1) begin
            if (pair == 0) begin
               yw = clip_s(1500 + tdiv(sticks[0], 500));
               if (cfg_mode == 0) thr = clip_s(1500 - tdiv(sticks[1], 50));
               else begin tgt = 1500 - tdiv(sticks[1], 50); thr = clip_s(thr); end
            end
            if (pair == 1) begin
               rol = clip_s(1500 + tdiv(sticks[3], 500));
               if (cfg_mode == 1 && sticks[2] > -29000) go_neutral();
            end
            if (pair == 2) begin
               pit = clip_s(1500 - tdiv(sticks[4], 500));
               arm_event(sticks[5] > 10000);
            end
         end else if (cfg_mode == 2) begin
            if (pair == 0) rol = clip_s(1500 + tdiv(sticks[0], 500));
            if (pair == 1) begin
               if (sticks[2] > 10000 && !rth) begin lth = 1; thr = 1250; end
               if (sticks[2] < 10000 && !rth) begin lth = 0; thr = mid; end
               yw = clip_s(1500 + tdiv(sticks[3], 500));
            end
            if (pair == 2) begin
               pit = clip_s(1500 - tdiv(sticks[4], 500));
               if (sticks[5] > 10000 && !lth) begin rth = 1; thr = 1550; end
               if (sticks[5] < 10000 && !lth) begin rth = 0; thr = mid; end
            end
         end else begin
            d = cfg_mode == 3 ? 500 : (cfg_mode == 4 ? 120 : 60);
            if (pair == 0) begin
               rol = clip_s(1500 + tdiv(sticks[0], d));
               pit = clip_s(1500 - tdiv(sticks[1], d));
            end
            if (pair == 1) yw = clip_s(1500 + tdiv(sticks[3], d));
            if (cfg_mode == 5) begin
               if (pair != 0) begin lt_last = sticks[2]; rt_last = sticks[5]; end
            end else begin
               if (pair == 1) lt_last = sticks[2];
               if (pair == 2) rt_last = sticks[5];
            end
            thr = clip_t(1300 + tdiv(rt_last - lt_last, cfg_mode == 3 ? 188 : 85));
         end
      end else if (w.command == CMD_TICK) begin
         if (cfg_mode == 1) begin
            if (tgt - 1500 > 100) thr += 1;
            if (tgt - 1500 < -100) thr -= 1;
            thr = clip_t(thr);
         end
         if (cfg_mode == 3) thr = clip_t(1300 + tdiv(rt_last - lt_last, 188));
      end
      r.throttle = 12'(thr); r.roll = 12'(rol); r.pitch = 12'(pit); r.yaw = 12'(yw);
      r.arm_channel = 11'(arm_lvl);
      channel_queue.push_back(r);
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         predict_channels(req_data);
         void'(pending_words.pop_front());
      end
      if (req_valid && req_stall) begin
      end else if (pending_words.size() > (req_valid && !req_stall ? 0 : 0) &&
                   $urandom_range(99) >= send_idle) begin
         req_valid <= 1;
         req_data <= pending_words[0];
      end else req_valid <= 0;
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (holdoff > 0) holdoff <= holdoff - 1;
   end

   // monitor
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (channel_queue.size() == 0) report("unexpected word", 0, 0);
         else begin
            rsp_word_type e;
            e = channel_queue.pop_front();
            if (rsp_data.throttle !== e.throttle) report("throttle", rsp_data.throttle, e.throttle);
            if (rsp_data.roll !== e.roll) report("roll", rsp_data.roll, e.roll);
            if (rsp_data.pitch !== e.pitch) report("pitch", rsp_data.pitch, e.pitch);
            if (rsp_data.yaw !== e.yaw) report("yaw", rsp_data.yaw, e.yaw);
            if (rsp_data.arm_channel !== e.arm_channel)
               report("arm_channel", rsp_data.arm_channel, e.arm_channel);
         end
      end
      if (holdoff > 0) rsp_stall <= 1;
      else rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   function automatic req_word_type rand_word();
      req_word_type w;
      int k;
      k = $urandom_range(99);
      w.command = k < 20 ? CMD_BUTTON : (k < 85 ? CMD_AXIS : (k < 97 ? CMD_TICK : 2'd3));
      w.number = $urandom_range(99) < 90 ? 8'($urandom_range(7)) : 8'($urandom);
      case ($urandom_range(4))
         0: w.value = 16'sh8000;
         1: w.value = 16'sh7fff;
         2: w.value = 16'($urandom_range(1));
         default: w.value = 16'($urandom);
      endcase
      return w;
   endfunction

   task automatic write_reg(logic idx, logic [2:0] val);
      @(posedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CSR_MODE) cfg_mode = val; else cfg_big = val;
   endtask

   task automatic drain();
      wait (pending_words.size() == 0 && channel_queue.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      req_word_type w;
      cfg_mode = 0; cfg_big = 0;
      foreach (sticks[i]) sticks[i] = 0;
      thr = 1239; rol = 1500; pit = 1500; yw = 1500; tgt = 1500; mid = 1500;
      arm_lvl = 900; armed = 0; lth = 0; rth = 0; lt_last = -32767; rt_last = -32767;
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed: extremes, arming, disconnect, ignored axis and command
      for (int i = 0; i < 6; i++) begin
         w.command = CMD_AXIS; w.number = 8'(i); w.value = i[0] ? 16'sh8000 : 16'sh7fff;
         pending_words.push_back(w);
      end
      w.command = CMD_BUTTON; w.number = 7; w.value = 1; pending_words.push_back(w);
      w.value = 0; pending_words.push_back(w);
      w.number = 5; w.value = 1; pending_words.push_back(w);
      w.command = CMD_AXIS; w.number = 8'hff; w.value = 100; pending_words.push_back(w);
      w.number = 6; pending_words.push_back(w);
      w.command = 2'd3; pending_words.push_back(w);
      w.command = CMD_TICK; pending_words.push_back(w);
      drain();
      for (int ph = 0; ph < 16; ph++) begin
         write_reg(CSR_MODE, 3'(ph % 6));
         write_reg(CSR_LAYOUT, 1'((ph / 6) % 2 ^ (ph >= 12)));
         case (ph % 4)
            0: begin send_idle = 0; recv_idle = 0; end
            1: begin send_idle = 79; recv_idle = 0; end
            2: begin send_idle = 0; recv_idle = 79; end
            default: begin send_idle = 36; recv_idle = 36; end
         endcase
         if (ph == 4) holdoff = 60;
         for (int i = 0; i < 46; i++) pending_words.push_back(rand_word());
         drain();
      end
      write_reg(CSR_MODE, 3'd7);
      for (int i = 0; i < 10; i++) pending_words.push_back(rand_word());
      drain();
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
